@@ rtl/tmhp_pkg.sv @@
// Package for the tensor model header parser.
// Holds phase encoding, result kinds and value-size helper. No dependencies.
package tmhp_pkg;

    localparam logic [31:0] FILE_MAGIC   = 32'h4655_4747;
    localparam logic [4:0]  HEADER_BYTES = 5'd24;
    localparam int          DATA_ALIGN_DEFAULT = 32;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERSION, PH_NTENS, PH_NKV, PH_KEYLEN, PH_KEYSKIP, PH_VTYPE,
        PH_VSKIP, PH_STRLEN, PH_ARRTYPE, PH_ARRLEN, PH_ELEMLEN, PH_ELEMSKIP,
        PH_NAMELEN, PH_NAMESKIP, PH_NDIMS, PH_DIMSKIP, PH_TTYPE, PH_TOFFSET,
        PH_BADWAIT, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_BADMAGIC = 2'd2,
        KIND_TRUNC    = 2'd3
    } kind_t;

    localparam logic [31:0] TYPE_STRING = 32'd8;
    localparam logic [31:0] TYPE_ARRAY  = 32'd9;

    // One result record
    typedef struct packed {
        kind_t       kind;
        logic [63:0] number;
        logic [63:0] name_len;
        logic [31:0] dims;
        logic [31:0] etype;
        logic [63:0] offset;
        logic [31:0] version;
    } rec_t;

    // Bytes taken by a scalar value of type t
    function automatic logic [3:0] value_size(input logic [31:0] t);
        logic [3:0] s;
        s = 4'd4;
        if (t < 32'd8) begin
            case (t[2:0])
                3'd0, 3'd1, 3'd7: s = 4'd1;
                3'd2, 3'd3:       s = 4'd2;
                default:          s = 4'd4;
            endcase
        end else if (t inside {[32'd10:32'd12]}) begin
            s = 4'd8;
        end
        return s;
    endfunction

endpackage

@@ rtl/tensor_model_header_parser_top.sv @@
// Tensor model header parser: top level.
// Channel in: data_byte, last_byte with in_valid / in_stall, one file byte per item.
// Channel out: one result record per item with out_valid / out_stall.
// Each byte updates the parse state in the cycle it is accepted; the records
// it causes (zero, one or two) enter a three-slot output queue of registers and
// appear on the out channel behind any records already queued. Throughput is
// one byte per cycle while at most one record waits in the queue; a byte that
// causes two records holds the input while the second record drains, and
// longer when the receiver stalls. in_stall rises when the queue holds two or
// more records. Reset (rst_n low, asynchronous) returns the parser to the
// magic field and empties the queue.
// A byte with last_byte set ends the file and the next byte starts a new one.
// DATA_ALIGN sets the rounding of the data start in the completion record.
module tensor_model_header_parser_top #(
    parameter int DATA_ALIGN = tmhp_pkg::DATA_ALIGN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [63:0] tensor_number,
    output logic [63:0] name_length,
    output logic [31:0] dim_count,
    output logic [31:0] elem_type,
    output logic [63:0] data_offset,
    output logic [31:0] format_version,
    output logic        last_of_run
);

    logic           can_push, step;
    logic [1:0]     rec_count, push_count;
    tmhp_pkg::rec_t rec0, rec1, head;

    assign in_stall   = !can_push;
    assign step       = in_valid && can_push;
    assign push_count = step ? rec_count : 2'd0;

    tmhp_core #(.DATA_ALIGN(DATA_ALIGN)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec_count (rec_count),
        .rec0      (rec0),
        .rec1      (rec1)
    );

    tmhp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (rec0),
        .push1      (rec1),
        .can_push   (can_push),
        .pop        (!out_stall),
        .head_valid (out_valid),
        .head       (head),
        .head_last  (last_of_run)
    );

    assign result_kind    = head.kind;
    assign tensor_number  = head.number;
    assign name_length    = head.name_len;
    assign dim_count      = head.dims;
    assign elem_type      = head.etype;
    assign data_offset    = head.offset;
    assign format_version = head.version;

endmodule

@@ rtl/tmhp_core.sv @@
// Byte-level parse engine: phase machine, field assembly, skip counters.
// Produces up to two records per byte. Uses tmhp_pkg.
module tmhp_core #(
    parameter int DATA_ALIGN = tmhp_pkg::DATA_ALIGN_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic [1:0]       rec_count,
    output tmhp_pkg::rec_t   rec0,
    output tmhp_pkg::rec_t   rec1
);

    localparam logic [63:0] ALIGN_W = 64'(DATA_ALIGN);
    localparam logic [11:0] MOD_TOP = 12'(DATA_ALIGN - 1);

    tmhp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [63:0] fshift_reg, fshift_next;
    logic [63:0] pos_reg, pos_next;
    logic [63:0] skip_reg, skip_next;
    logic [63:0] pairs_reg, pairs_next;
    logic [63:0] ents_reg, ents_next;
    logic [63:0] emitted_reg, emitted_next;
    logic [63:0] arr_reg, arr_next;
    logic [31:0] atype_reg, atype_next;
    logic [31:0] ver_reg, ver_next;
    logic [63:0] hname_reg, hname_next;
    logic [31:0] hdims_reg, hdims_next;
    logic [31:0] htype_reg, htype_next;

    // Aligned data start: position after this byte rounded up. The
    // remainder of the rounding sum is tracked by a small running counter.
    logic [63:0] round_sum, aligned;
    logic [11:0] amod_reg, amod_next, amod_step;
    assign round_sum = pos_reg + ALIGN_W;
    assign amod_step = (round_sum == 64'd0 || amod_reg == MOD_TOP) ? 12'd0 :
                       amod_reg + 12'd1;
    assign aligned   = round_sum - 64'(amod_step);
    assign amod_next = last_byte ? MOD_TOP : amod_step;

    // Field assembly
    logic [63:0] got;
    logic        d4, d8;
    assign got = fshift_reg | (64'(data_byte) << {fcnt_reg[2:0], 3'b000});
    assign d4  = fcnt_reg >= 4'd3;
    assign d8  = fcnt_reg >= 4'd7;
    logic [63:0] skip_dec;
    assign skip_dec = skip_reg - 64'd1;

    // Next-state logic
    always_comb
    begin
        logic take_done;
        logic do_end_pair, do_next_elem, do_start, do_complete;
        logic [63:0] pairs_dec, arr_cur, ents_cur;
        phase_next   = phase_reg;
        fcnt_next    = fcnt_reg;
        fshift_next  = fshift_reg;
        pos_next     = pos_reg + 64'd1;
        skip_next    = skip_reg;
        pairs_next   = pairs_reg;
        ents_next    = ents_reg;
        emitted_next = emitted_reg;
        arr_next     = arr_reg;
        atype_next   = atype_reg;
        ver_next     = ver_reg;
        hname_next   = hname_reg;
        hdims_next   = hdims_reg;
        htype_next   = htype_reg;
        take_done    = 1'b0;
        do_end_pair  = 1'b0;
        do_next_elem = 1'b0;
        do_start     = 1'b0;
        do_complete  = 1'b0;
        pairs_dec    = pairs_reg;
        arr_cur      = arr_reg;
        ents_cur     = ents_reg;
        rec_count    = 2'd0;
        rec0         = '0;
        rec1         = '0;

        // Byte gathering for multi-byte fields
        case (phase_reg)
            tmhp_pkg::PH_MAGIC, tmhp_pkg::PH_VERSION, tmhp_pkg::PH_VTYPE,
            tmhp_pkg::PH_ARRTYPE, tmhp_pkg::PH_NDIMS, tmhp_pkg::PH_TTYPE:
                take_done = d4;
            tmhp_pkg::PH_NTENS, tmhp_pkg::PH_NKV, tmhp_pkg::PH_KEYLEN,
            tmhp_pkg::PH_STRLEN, tmhp_pkg::PH_ARRLEN, tmhp_pkg::PH_ELEMLEN,
            tmhp_pkg::PH_NAMELEN, tmhp_pkg::PH_TOFFSET:
                take_done = d8;
            default:
                take_done = 1'b0;
        endcase
        case (phase_reg)
            tmhp_pkg::PH_KEYSKIP, tmhp_pkg::PH_VSKIP, tmhp_pkg::PH_ELEMSKIP,
            tmhp_pkg::PH_NAMESKIP, tmhp_pkg::PH_DIMSKIP,
            tmhp_pkg::PH_BADWAIT, tmhp_pkg::PH_DONE: ;
            default:
            begin
                if (take_done) begin
                    fshift_next = '0;
                    fcnt_next   = '0;
                end else begin
                    fshift_next = got;
                    fcnt_next   = fcnt_reg + 4'd1;
                end
            end
        endcase

        case (phase_reg)
            tmhp_pkg::PH_MAGIC:
                if (take_done)
                    phase_next = (got[31:0] == tmhp_pkg::FILE_MAGIC) ?
                                 tmhp_pkg::PH_VERSION : tmhp_pkg::PH_BADWAIT;
            tmhp_pkg::PH_VERSION:
                if (take_done) begin
                    ver_next   = got[31:0];
                    phase_next = tmhp_pkg::PH_NTENS;
                end
            tmhp_pkg::PH_NTENS:
                if (take_done) begin
                    ents_next  = got;
                    ents_cur   = got;
                    phase_next = tmhp_pkg::PH_NKV;
                end
            tmhp_pkg::PH_NKV:
                if (take_done) begin
                    pairs_next = got;
                    if (got == 64'd0) do_start = 1'b1;
                    else phase_next = tmhp_pkg::PH_KEYLEN;
                end
            tmhp_pkg::PH_KEYLEN:
                if (take_done) begin
                    if (got == 64'd0) phase_next = tmhp_pkg::PH_VTYPE;
                    else begin
                        skip_next  = got;
                        phase_next = tmhp_pkg::PH_KEYSKIP;
                    end
                end
            tmhp_pkg::PH_KEYSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 64'd0) phase_next = tmhp_pkg::PH_VTYPE;
            end
            tmhp_pkg::PH_VTYPE:
                if (take_done) begin
                    if (got[31:0] == tmhp_pkg::TYPE_STRING)
                        phase_next = tmhp_pkg::PH_STRLEN;
                    else if (got[31:0] == tmhp_pkg::TYPE_ARRAY)
                        phase_next = tmhp_pkg::PH_ARRTYPE;
                    else begin
                        skip_next  = 64'(tmhp_pkg::value_size(got[31:0]));
                        phase_next = tmhp_pkg::PH_VSKIP;
                    end
                end
            tmhp_pkg::PH_VSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 64'd0) do_end_pair = 1'b1;
            end
            tmhp_pkg::PH_STRLEN:
                if (take_done) begin
                    if (got == 64'd0) do_end_pair = 1'b1;
                    else begin
                        skip_next  = got;
                        phase_next = tmhp_pkg::PH_VSKIP;
                    end
                end
            tmhp_pkg::PH_ARRTYPE:
                if (take_done) begin
                    atype_next = got[31:0];
                    phase_next = tmhp_pkg::PH_ARRLEN;
                end
            tmhp_pkg::PH_ARRLEN:
                if (take_done) begin
                    arr_cur      = got;
                    do_next_elem = 1'b1;
                end
            tmhp_pkg::PH_ELEMLEN:
                if (take_done) begin
                    if (got == 64'd0) do_next_elem = 1'b1;
                    else begin
                        skip_next  = got;
                        phase_next = tmhp_pkg::PH_ELEMSKIP;
                    end
                end
            tmhp_pkg::PH_ELEMSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 64'd0) do_next_elem = 1'b1;
            end
            tmhp_pkg::PH_NAMELEN:
                if (take_done) begin
                    hname_next = got;
                    if (got == 64'd0) phase_next = tmhp_pkg::PH_NDIMS;
                    else begin
                        skip_next  = got;
                        phase_next = tmhp_pkg::PH_NAMESKIP;
                    end
                end
            tmhp_pkg::PH_NAMESKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 64'd0) phase_next = tmhp_pkg::PH_NDIMS;
            end
            tmhp_pkg::PH_NDIMS:
                if (take_done) begin
                    hdims_next = got[31:0];
                    if (got[31:0] == 32'd0) phase_next = tmhp_pkg::PH_TTYPE;
                    else begin
                        skip_next  = {29'd0, got[31:0], 3'b000};
                        phase_next = tmhp_pkg::PH_DIMSKIP;
                    end
                end
            tmhp_pkg::PH_DIMSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 64'd0) phase_next = tmhp_pkg::PH_TTYPE;
            end
            tmhp_pkg::PH_TTYPE:
                if (take_done) begin
                    htype_next = got[31:0];
                    phase_next = tmhp_pkg::PH_TOFFSET;
                end
            tmhp_pkg::PH_TOFFSET:
                if (take_done) begin
                    rec_count    = 2'd1;
                    rec0.kind    = tmhp_pkg::KIND_ENTRY;
                    rec0.number  = emitted_reg;
                    rec0.name_len = hname_reg;
                    rec0.dims    = hdims_reg;
                    rec0.etype   = htype_reg;
                    rec0.offset  = got;
                    rec0.version = ver_reg;
                    emitted_next = emitted_reg + 64'd1;
                    ents_next    = ents_reg - 64'd1;
                    if (ents_next == 64'd0) do_complete = 1'b1;
                    else phase_next = tmhp_pkg::PH_NAMELEN;
                end
            tmhp_pkg::PH_BADWAIT:
                if (pos_next >= 64'(tmhp_pkg::HEADER_BYTES)) begin
                    rec_count  = 2'd1;
                    rec0.kind  = tmhp_pkg::KIND_BADMAGIC;
                    phase_next = tmhp_pkg::PH_DONE;
                end
            default: ;
        endcase

        // Array element sequencing
        if (do_next_elem) begin
            if (arr_cur == 64'd0) do_end_pair = 1'b1;
            else begin
                arr_next = arr_cur - 64'd1;
                if (atype_reg == tmhp_pkg::TYPE_STRING)
                    phase_next = tmhp_pkg::PH_ELEMLEN;
                else begin
                    skip_next  = 64'(tmhp_pkg::value_size(atype_reg));
                    phase_next = tmhp_pkg::PH_ELEMSKIP;
                end
            end
        end
        if (do_end_pair) begin
            pairs_dec  = pairs_reg - 64'd1;
            pairs_next = pairs_dec;
            if (pairs_dec == 64'd0) do_start = 1'b1;
            else phase_next = tmhp_pkg::PH_KEYLEN;
        end
        if (do_start) begin
            if (ents_cur == 64'd0) do_complete = 1'b1;
            else phase_next = tmhp_pkg::PH_NAMELEN;
        end
        if (do_complete) begin
            phase_next = tmhp_pkg::PH_DONE;
            if (rec_count == 2'd0) begin
                rec_count    = 2'd1;
                rec0.kind    = tmhp_pkg::KIND_COMPLETE;
                rec0.number  = emitted_next;
                rec0.offset  = aligned;
                rec0.version = ver_next;
            end else begin
                rec_count    = 2'd2;
                rec1.kind    = tmhp_pkg::KIND_COMPLETE;
                rec1.number  = emitted_next;
                rec1.offset  = aligned;
                rec1.version = ver_next;
            end
        end

        // End of file: report a cut stream if the header is unfinished, then return to reset
        if (last_byte) begin
            if (phase_next != tmhp_pkg::PH_DONE) begin
                if (rec_count == 2'd0) begin
                    rec_count    = 2'd1;
                    rec0.kind    = tmhp_pkg::KIND_TRUNC;
                    rec0.number  = emitted_next;
                    rec0.version = ver_next;
                end else begin
                    rec_count    = 2'd2;
                    rec1.kind    = tmhp_pkg::KIND_TRUNC;
                    rec1.number  = emitted_next;
                    rec1.version = ver_next;
                end
            end
            phase_next   = tmhp_pkg::PH_MAGIC;
            fcnt_next    = '0;
            fshift_next  = '0;
            pos_next     = '0;
            skip_next    = '0;
            pairs_next   = '0;
            ents_next    = '0;
            emitted_next = '0;
            arr_next     = '0;
            atype_next   = '0;
            ver_next     = '0;
            hname_next   = '0;
            hdims_next   = '0;
            htype_next   = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= tmhp_pkg::PH_MAGIC;
            fcnt_reg    <= '0;
            fshift_reg  <= '0;
            pos_reg     <= '0;
            amod_reg    <= MOD_TOP;
            skip_reg    <= '0;
            pairs_reg   <= '0;
            ents_reg    <= '0;
            emitted_reg <= '0;
            arr_reg     <= '0;
            atype_reg   <= '0;
            ver_reg     <= '0;
            hname_reg   <= '0;
            hdims_reg   <= '0;
            htype_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            fcnt_reg    <= fcnt_next;
            fshift_reg  <= fshift_next;
            pos_reg     <= pos_next;
            amod_reg    <= amod_next;
            skip_reg    <= skip_next;
            pairs_reg   <= pairs_next;
            ents_reg    <= ents_next;
            emitted_reg <= emitted_next;
            arr_reg     <= arr_next;
            atype_reg   <= atype_next;
            ver_reg     <= ver_next;
            hname_reg   <= hname_next;
            hdims_reg   <= hdims_next;
            htype_reg   <= htype_next;
        end
    end

    // Field counter never runs past an 8-byte field
    assert property (@(posedge clk) disable iff (!rst_n) fcnt_reg <= 4'd7)
        else $error("field byte count overflow");
    // A second record is only ever a completion or truncation
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_count == 2'd2) |->
        (rec1.kind == tmhp_pkg::KIND_COMPLETE || rec1.kind == tmhp_pkg::KIND_TRUNC))
        else $error("bad second record");
    // Every file ends back at the magic phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> (phase_reg == tmhp_pkg::PH_MAGIC))
        else $error("no reset after last byte");

endmodule

@@ rtl/tmhp_outq.sv @@
// Output queue: holds up to three pending records and presents them one
// per item on the result channel. Uses tmhp_pkg.
module tmhp_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  tmhp_pkg::rec_t   push0,
    input  tmhp_pkg::rec_t   push1,
    output logic             can_push,
    input  logic             pop,
    output logic             head_valid,
    output tmhp_pkg::rec_t   head,
    output logic             head_last
);

    // Three slots: a group of two may enter while one waits
    tmhp_pkg::rec_t slot_reg [3];
    tmhp_pkg::rec_t slot_next [3];
    logic [2:0] last_reg, last_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] pop_n;
    logic [1:0] base;

    assign head_valid = cnt_reg != 2'd0;
    assign head       = slot_reg[0];
    assign head_last  = last_reg[0];
    assign pop_n      = (pop && head_valid) ? 2'd1 : 2'd0;
    assign can_push   = cnt_reg <= 2'd1;
    assign cnt_next   = cnt_reg - pop_n + push_count;
    assign base       = cnt_reg - pop_n;

    // Slot shifting and append
    always_comb
    begin
        slot_next = slot_reg;
        last_next = last_reg;
        if (pop_n == 2'd1) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            last_next[0] = last_reg[1];
            last_next[1] = last_reg[2];
        end
        if (push_count != 2'd0) begin
            slot_next[base] = push0;
            last_next[base] = push_count == 2'd1;
        end
        if (push_count == 2'd2) begin
            slot_next[base + 2'd1] = push1;
            last_next[base + 2'd1] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            last_reg <= '0;
            slot_reg <= '{default: '0};
        end else begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            slot_reg <= slot_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd3)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> can_push)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !pop) |=> head_valid)
        else $error("record dropped");

endmodule
